FILE: rtl/core/tpcp_pkg.sv
// ----------------------------------------------------------------------------
// Thermal printer command parser package
// Event codes, command byte codes, queue record type and shared constants.
// ----------------------------------------------------------------------------
package tpcp_pkg;

   // Fixed widths of the stream and of the result fields.
   localparam int BYTE_W  = 8;
   localparam int LINES_W = 12;
   localparam int COUNT_W = 18;

   localparam int                   MAX_BITMAP_LINES_DEF = 1023;
   localparam logic [COUNT_W-1:0]   COUNT_MAX            = 18'h3FFFF;
   localparam int                   QUEUE_DEPTH_DEF      = 4;
   localparam logic [15:0]          LSPACE_DEFAULT       = 16'd16;

   // Event codes as they leave the block.
   typedef enum logic [4:0] {
      EV_CHAR          = 5'd0,
      EV_WIDE          = 5'd1,
      EV_LINE_END      = 5'd2,
      EV_CUT           = 5'd3,
      EV_LINE_SPACE    = 5'd4,
      EV_REVERSE       = 5'd5,
      EV_FEED_FWD      = 5'd6,
      EV_FEED_REV      = 5'd7,
      EV_CHAR_SPACE    = 5'd8,
      EV_DBL_WIDTH     = 5'd9,
      EV_DBL_HEIGHT    = 5'd10,
      EV_UNDERLINE     = 5'd11,
      EV_BMP_MSB       = 5'd12,
      EV_XOR_MODE      = 5'd13,
      EV_FONT_SEL      = 5'd14,
      EV_CUSTOM_EN     = 5'd15,
      EV_PEN_ADV       = 5'd16,
      EV_BMP_PRINT     = 5'd17,
      EV_BMP_DELETE    = 5'd18,
      EV_BMP_HEADER    = 5'd19,
      EV_BMP_DATA      = 5'd20,
      EV_FONT_HEADER   = 5'd21,
      EV_FONT_DATA     = 5'd22,
      EV_RULED_MODE    = 5'd23,
      EV_RULED_CLEAR   = 5'd24,
      EV_RULED_RANGE   = 5'd25,
      EV_RULED_PATTERN = 5'd26,
      EV_RULED_PRINT   = 5'd27
   } ev_type;

   // Parser modes.
   typedef enum logic [1:0] {
      MODE_TEXT = 2'd0,
      MODE_ESC  = 2'd1,
      MODE_DC2  = 2'd2,
      MODE_DC3  = 2'd3
   } mode_type;

   // Control bytes of the text stream.
   localparam logic [7:0] B_NUL = 8'h00;
   localparam logic [7:0] B_LF  = 8'h0A;
   localparam logic [7:0] B_CR  = 8'h0D;
   localparam logic [7:0] B_DC2 = 8'h12;
   localparam logic [7:0] B_DC3 = 8'h13;
   localparam logic [7:0] B_CAN = 8'h18;
   localparam logic [7:0] B_ESC = 8'h1B;
   localparam logic [7:0] B_SPC = 8'h20;

   // Command bytes.
   localparam logic [7:0] C_HASH   = 8'h23;
   localparam logic [7:0] C_LPAR   = 8'h28;
   localparam logic [7:0] C_RPAR   = 8'h29;
   localparam logic [7:0] C_PLUS   = 8'h2B;
   localparam logic [7:0] C_MINUS  = 8'h2D;
   localparam logic [7:0] C_TWO    = 8'h32;
   localparam logic [7:0] C_THREE  = 8'h33;
   localparam logic [7:0] C_EQUAL  = 8'h3D;
   localparam logic [7:0] C_UA     = 8'h41;
   localparam logic [7:0] C_UC     = 8'h43;
   localparam logic [7:0] C_UD     = 8'h44;
   localparam logic [7:0] C_UF     = 8'h46;
   localparam logic [7:0] C_UG     = 8'h47;
   localparam logic [7:0] C_UH     = 8'h48;
   localparam logic [7:0] C_UI     = 8'h49;
   localparam logic [7:0] C_UJ     = 8'h4A;
   localparam logic [7:0] C_UK     = 8'h4B;
   localparam logic [7:0] C_UL     = 8'h4C;
   localparam logic [7:0] C_UO     = 8'h4F;
   localparam logic [7:0] C_UP     = 8'h50;
   localparam logic [7:0] C_US     = 8'h53;
   localparam logic [7:0] C_UT     = 8'h54;
   localparam logic [7:0] C_UU     = 8'h55;
   localparam logic [7:0] C_UW     = 8'h57;
   localparam logic [7:0] C_LI     = 8'h69;
   localparam logic [7:0] C_LJ     = 8'h6A;
   localparam logic [7:0] C_LM     = 8'h6D;
   localparam logic [7:0] C_LP     = 8'h70;
   localparam logic [7:0] C_LW     = 8'h77;
   localparam logic [7:0] C_TILDE  = 8'h7E;

   // One classified command between the front and the back.
   typedef struct packed {
      ev_type     ev;
      logic [7:0] p0;
      logic [7:0] p1;
      logic [7:0] p2;
      logic [7:0] p3;
      logic       last;
   } rec_type;

endpackage

FILE: rtl/core/tpcp_ifs.sv
// ----------------------------------------------------------------------------
// Thermal printer command parser channels
// Valid/ready channels for the byte stream and for decoded events.
// ----------------------------------------------------------------------------
interface tpcp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;

   modport source (output valid, output byte_in, input ready);
   modport sink (input valid, input byte_in, output ready);
endinterface

interface tpcp_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  event_res;
   logic [15:0] arg_a;
   logic [15:0] arg_b;
   logic [7:0]  arg_c;
   logic [7:0]  arg_d;
   logic        payload_last;

   modport source (output valid, output event_res, output arg_a, output arg_b,
                   output arg_c, output arg_d, output payload_last, input ready);
   modport sink (input valid, input event_res, input arg_a, input arg_b,
                 input arg_c, input arg_d, input payload_last, output ready);
endinterface

FILE: rtl/core/tpcp_queue.sv
// ----------------------------------------------------------------------------
// Thermal printer command parser record queue
// Small register queue between the parser front and the event formatter.
// DEPTH must be a power of two.
// ----------------------------------------------------------------------------
module tpcp_queue import tpcp_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rec_type push_rec,
   input  logic    pop,
   output logic    full,
   output logic    not_empty,
   output rec_type head
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   rec_type         mem_ff [DEPTH];
   logic [AW-1:0]   wptr_ff, wptr_in;
   logic [AW-1:0]   rptr_ff, rptr_in;
   logic [AW:0]     count_ff, count_in;

   // Status and head of queue.
   assign full      = (count_ff == (AW+1)'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wptr_in  = push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = pop ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= push_rec;
      end
   end

endmodule

FILE: rtl/core/tpcp_front.sv
// ----------------------------------------------------------------------------
// Thermal printer command parser front
// Accepts stream bytes, tracks the parse state and queues classified commands.
// ----------------------------------------------------------------------------
module tpcp_front import tpcp_pkg::*; #(
   parameter int MAX_BITMAP_LINES = MAX_BITMAP_LINES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   tpcp_req_if.sink    req,
   input  logic        q_full,
   output logic        push,
   output rec_type     push_rec
);

   localparam logic [LINES_W-1:0] MAX_LINES = LINES_W'(MAX_BITMAP_LINES);

   typedef enum logic [1:0] {FS_IDLE, FS_MUL1, FS_MUL2} fsm_type;

   fsm_type              fsm_ff, fsm_in;
   mode_type             mode_ff, mode_in;
   logic                 locked_ff, locked_in;
   logic [7:0]           cmd_ff, cmd_in;
   logic [COUNT_W-1:0]   rem_ff, rem_in;
   logic [7:0]           par_ff [4];
   logic [7:0]           par_in [4];
   logic [2:0]           pcnt_ff, pcnt_in;
   logic                 kanji_ff, kanji_in;
   logic [7:0]           kfirst_ff, kfirst_in;
   logic [11:0]          m1_ff, m1_in;
   logic signed [12:0]   m2_ff, m2_in;

   logic                 accept;
   logic [7:0]           c;
   logic                 do_finish;
   logic [4:0]           ceil_y;
   logic signed [9:0]    span;
   logic [15:0]          h_raw;
   logic [LINES_W-1:0]   h_clamp;
   logic signed [25:0]   prod;
   logic [COUNT_W-1:0]   cnt;

   assign req.ready = (fsm_ff == FS_IDLE) && !q_full;
   assign accept    = req.valid && req.ready;
   assign c         = req.byte_in;

   // Payload count terms; the first product is registered before the second.
   always_comb begin
      ceil_y  = 5'((9'(par_ff[2][6:0]) + 9'd7) >> 3);
      span    = $signed({2'b00, par_ff[1]}) - $signed({2'b00, par_ff[0]}) + 10'sd1;
      h_raw   = {par_ff[3], par_ff[2]};
      h_clamp = (h_raw > 16'(MAX_LINES)) ? MAX_LINES : h_raw[LINES_W-1:0];
      prod    = $signed({1'b0, m1_ff}) * m2_ff;
      if (prod <= 26'sd0) begin
         cnt = '0;
      end else if (prod > 26'sd262143) begin
         cnt = COUNT_MAX;
      end else begin
         cnt = prod[COUNT_W-1:0];
      end
   end

   // Parse step for one accepted beat, and the header count sequence.
   always_comb begin
      fsm_in    = fsm_ff;
      mode_in   = mode_ff;
      locked_in = locked_ff;
      cmd_in    = cmd_ff;
      rem_in    = rem_ff;
      par_in    = par_ff;
      pcnt_in   = pcnt_ff;
      kanji_in  = kanji_ff;
      kfirst_in = kfirst_ff;
      m1_in     = m1_ff;
      m2_in     = m2_ff;
      push      = 1'b0;
      push_rec  = '0;
      do_finish = 1'b0;

      unique case (fsm_ff)
         FS_MUL1: begin
            if (cmd_ff == C_UT) begin
               m1_in = {5'b0, par_ff[1][6:0]};
               m2_in = $signed({1'b0, h_clamp});
            end else begin
               m1_in = 12'(ceil_y * par_ff[3][6:0]);
               m2_in = 13'(span);
            end
            fsm_in = FS_MUL2;
         end
         FS_MUL2: begin
            if (!q_full) begin
               push        = 1'b1;
               push_rec.p0 = par_ff[0];
               push_rec.p1 = par_ff[1];
               if (cmd_ff == C_UT) begin
                  push_rec.ev = EV_BMP_HEADER;
                  push_rec.p2 = m2_ff[7:0];
                  push_rec.p3 = {4'b0, m2_ff[11:8]};
               end else begin
                  push_rec.ev = EV_FONT_HEADER;
                  push_rec.p2 = par_ff[2];
                  push_rec.p3 = par_ff[3];
               end
               rem_in = cnt;
               if (cnt == '0) begin
                  do_finish = 1'b1;
               end
               fsm_in = FS_IDLE;
            end
         end
         default: begin
            if (accept) begin
               if (rem_ff != '0) begin
                  if (pcnt_ff >= 3'd4) begin
                     // Payload beat of a bitmap or font definition.
                     push          = 1'b1;
                     push_rec.ev   = (cmd_ff == C_UT) ? EV_BMP_DATA : EV_FONT_DATA;
                     push_rec.p0   = c;
                     push_rec.last = (rem_ff == COUNT_W'(1));
                     rem_in        = rem_ff - 1'b1;
                     do_finish     = (rem_ff == COUNT_W'(1));
                  end else begin
                     // Parameter beat; the last one runs the command.
                     par_in[pcnt_ff[1:0]] = c;
                     pcnt_in              = pcnt_ff + 1'b1;
                     rem_in               = rem_ff - 1'b1;
                     if (rem_ff == COUNT_W'(1)) begin
                        push_rec.p0 = par_in[0];
                        push_rec.p1 = par_in[1];
                        push_rec.p2 = par_in[2];
                        push_rec.p3 = par_in[3];
                        do_finish   = 1'b1;
                        unique case (mode_ff)
                           MODE_ESC: begin
                              push = 1'b1;
                              priority case (cmd_ff)
                                 C_THREE, C_UA: push_rec.ev = EV_LINE_SPACE;
                                 C_UI:          push_rec.ev = EV_REVERSE;
                                 C_UJ:          push_rec.ev = EV_FEED_FWD;
                                 C_LJ:          push_rec.ev = EV_FEED_REV;
                                 B_SPC:         push_rec.ev = EV_CHAR_SPACE;
                                 C_UW:          push_rec.ev = EV_DBL_WIDTH;
                                 C_LW:          push_rec.ev = EV_DBL_HEIGHT;
                                 C_MINUS:       push_rec.ev = EV_UNDERLINE;
                                 C_EQUAL:       push_rec.ev = EV_BMP_MSB;
                                 C_HASH:        push_rec.ev = EV_XOR_MODE;
                                 default:       push = 1'b0;
                              endcase
                           end
                           MODE_DC2: begin
                              priority case (cmd_ff)
                                 C_UF: begin
                                    push        = 1'b1;
                                    push_rec.ev = EV_FONT_SEL;
                                 end
                                 C_UO: begin
                                    push        = 1'b1;
                                    push_rec.ev = EV_CUSTOM_EN;
                                 end
                                 C_LP: begin
                                    push        = (par_in[0] != 8'd0);
                                    push_rec.ev = EV_PEN_ADV;
                                 end
                                 C_US: begin
                                    push        = 1'b1;
                                    push_rec.ev = EV_BMP_PRINT;
                                 end
                                 C_UU: begin
                                    push        = 1'b1;
                                    push_rec.ev = EV_BMP_DELETE;
                                 end
                                 C_UT, C_UP: begin
                                    do_finish = 1'b0;
                                    fsm_in    = FS_MUL1;
                                 end
                                 default: push = 1'b0;
                              endcase
                           end
                           MODE_DC3: begin
                              priority case (cmd_ff)
                                 C_UD: begin
                                    push        = 1'b1;
                                    push_rec.ev = EV_RULED_RANGE;
                                    push_rec.p2 = par_in[0];
                                    push_rec.p3 = par_in[1];
                                 end
                                 C_UF: begin
                                    push        = 1'b1;
                                    push_rec.ev = EV_RULED_PATTERN;
                                 end
                                 C_UL: begin
                                    push        = 1'b1;
                                    push_rec.ev = EV_RULED_RANGE;
                                 end
                                 default: push = 1'b0;
                              endcase
                           end
                           default: push = 1'b0;
                        endcase
                     end
                  end
               end else begin
                  unique case (mode_ff)
                     MODE_ESC: begin
                        cmd_in = c;
                        priority case (c)
                           C_THREE, C_UA, C_UJ, C_LJ, B_SPC, C_UI, C_UW, C_LW,
                           C_EQUAL, C_HASH, C_MINUS: begin
                              rem_in  = COUNT_W'(1);
                              pcnt_in = 3'd0;
                           end
                           C_LI: begin
                              mode_in     = MODE_TEXT;
                              push        = 1'b1;
                              push_rec.ev = EV_CUT;
                           end
                           C_UK: begin
                              kanji_in = 1'b1;
                              mode_in  = MODE_TEXT;
                           end
                           C_UH: begin
                              kanji_in = 1'b0;
                              mode_in  = MODE_TEXT;
                           end
                           C_TWO: begin
                              mode_in     = MODE_TEXT;
                              push        = 1'b1;
                              push_rec.ev = EV_LINE_SPACE;
                              push_rec.p0 = LSPACE_DEFAULT[7:0];
                           end
                           default: mode_in = MODE_TEXT;
                        endcase
                     end
                     MODE_DC2: begin
                        cmd_in  = c;
                        pcnt_in = 3'd0;
                        priority case (c)
                           C_UD, C_UF, C_UG, C_UU, C_LP, C_TILDE, C_UO:
                              rem_in = COUNT_W'(1);
                           C_US:       rem_in = COUNT_W'(2);
                           C_LM:       rem_in = COUNT_W'(3);
                           C_UT, C_UP: rem_in = COUNT_W'(4);
                           default:    mode_in = MODE_TEXT;
                        endcase
                     end
                     MODE_DC3: begin
                        cmd_in = c;
                        if (!locked_ff) begin
                           mode_in = MODE_TEXT;
                        end
                        priority case (c)
                           C_LPAR: begin
                              locked_in = 1'b1;
                              mode_in   = mode_ff;
                           end
                           C_RPAR: begin
                              locked_in = 1'b0;
                              mode_in   = MODE_TEXT;
                           end
                           C_UD, C_UF: begin
                              rem_in  = COUNT_W'(2);
                              pcnt_in = 3'd0;
                              mode_in = mode_ff;
                           end
                           C_UL: begin
                              rem_in  = COUNT_W'(4);
                              pcnt_in = 3'd0;
                              mode_in = mode_ff;
                           end
                           C_PLUS: begin
                              push        = 1'b1;
                              push_rec.ev = EV_RULED_MODE;
                              push_rec.p0 = 8'd1;
                           end
                           C_MINUS: begin
                              push        = 1'b1;
                              push_rec.ev = EV_RULED_MODE;
                           end
                           C_UC: begin
                              push        = 1'b1;
                              push_rec.ev = EV_RULED_CLEAR;
                           end
                           C_UP: begin
                              push        = 1'b1;
                              push_rec.ev = EV_RULED_PRINT;
                           end
                           default: push = 1'b0;
                        endcase
                     end
                     default: begin
                        // Text mode, with kanji pairing.
                        priority case (c)
                           B_ESC: mode_in = MODE_ESC;
                           B_DC2: mode_in = MODE_DC2;
                           B_DC3: mode_in = MODE_DC3;
                           B_CR, B_LF: begin
                              push        = 1'b1;
                              push_rec.ev = EV_LINE_END;
                           end
                           B_CAN, B_NUL: push = 1'b0;
                           default: begin
                              if (!kanji_ff || (kfirst_ff == 8'd0 && c <= B_SPC)) begin
                                 push        = 1'b1;
                                 push_rec.ev = EV_CHAR;
                                 push_rec.p0 = c;
                              end else if (kfirst_ff == 8'd0) begin
                                 kfirst_in = c;
                              end else begin
                                 push        = 1'b1;
                                 push_rec.ev = EV_WIDE;
                                 push_rec.p0 = kfirst_ff;
                                 push_rec.p1 = c;
                                 kfirst_in   = 8'd0;
                              end
                           end
                        endcase
                     end
                  endcase
               end
            end
         end
      endcase

      // End of a command: locked DC3 stays in DC3.
      if (do_finish) begin
         rem_in  = '0;
         pcnt_in = 3'd0;
         if (!(locked_ff && mode_ff == MODE_DC3)) begin
            mode_in = MODE_TEXT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff    <= FS_IDLE;
         mode_ff   <= MODE_TEXT;
         locked_ff <= 1'b0;
         cmd_ff    <= '0;
         rem_ff    <= '0;
         pcnt_ff   <= '0;
         kanji_ff  <= 1'b0;
         kfirst_ff <= '0;
      end else begin
         fsm_ff    <= fsm_in;
         mode_ff   <= mode_in;
         locked_ff <= locked_in;
         cmd_ff    <= cmd_in;
         rem_ff    <= rem_in;
         pcnt_ff   <= pcnt_in;
         kanji_ff  <= kanji_in;
         kfirst_ff <= kfirst_in;
      end
   end

   // Parameter bytes and count operands hold no reset value.
   always_ff @(posedge clock) begin
      par_ff <= par_in;
      m1_ff  <= m1_in;
      m2_ff  <= m2_in;
   end

`ifndef SYNTHESIS
   // The first count step is always followed by the second.
   a_mul_seq: assert property (@(posedge clock) disable iff (reset)
      fsm_ff == FS_MUL1 |=> fsm_ff == FS_MUL2)
      else $error("count sequence skipped its second step");

   // Only DC2 header commands enter the count sequence.
   a_mul_mode: assert property (@(posedge clock) disable iff (reset)
      fsm_ff != FS_IDLE |-> mode_ff == MODE_DC2 && (cmd_ff == C_UT || cmd_ff == C_UP))
      else $error("count sequence outside a DC2 header command");

   // The parameter count never passes four.
   a_pcnt: assert property (@(posedge clock) disable iff (reset)
      pcnt_ff <= 3'd4)
      else $error("parameter count overflow");
`endif

endmodule

FILE: rtl/core/tpcp_back.sv
// ----------------------------------------------------------------------------
// Thermal printer command parser back
// Turns queued commands into event arguments and holds the result beat.
// ----------------------------------------------------------------------------
module tpcp_back import tpcp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  rec_type     q_head,
   output logic        pop,
   tpcp_rsp_if.source  rsp
);

   logic        valid_ff, valid_in;
   ev_type      ev_ff;
   logic [15:0] a_ff, a_in;
   logic [15:0] b_ff, b_in;
   logic [7:0]  c_ff, c_in;
   logic [7:0]  d_ff, d_in;
   logic        last_ff;
   logic        load;

   // Load the output register whenever it is free or being taken.
   assign load     = q_valid && (!valid_ff || rsp.ready);
   assign pop      = load;
   assign valid_in = load || (valid_ff && !rsp.ready);

   // Argument formatting per event.
   always_comb begin
      a_in = '0;
      b_in = '0;
      c_in = '0;
      d_in = '0;
      unique case (q_head.ev)
         EV_CHAR, EV_LINE_SPACE, EV_FEED_FWD, EV_FEED_REV, EV_BMP_DELETE,
         EV_RULED_MODE, EV_BMP_DATA, EV_FONT_DATA:
            a_in = {8'd0, q_head.p0};
         EV_WIDE:
            a_in = {q_head.p0, q_head.p1};
         EV_REVERSE, EV_DBL_WIDTH, EV_DBL_HEIGHT, EV_BMP_MSB, EV_XOR_MODE,
         EV_FONT_SEL, EV_CUSTOM_EN:
            a_in = {15'd0, q_head.p0[0]};
         EV_CHAR_SPACE:
            a_in = {9'd0, q_head.p0[6:0]};
         EV_UNDERLINE:
            a_in = {13'd0, q_head.p0[2:0]};
         EV_PEN_ADV:
            a_in = 16'd1;
         EV_BMP_PRINT: begin
            a_in = {8'd0, q_head.p0};
            b_in = {5'd0, q_head.p1, 3'd0};
         end
         EV_BMP_HEADER: begin
            a_in = {8'd0, q_head.p0};
            b_in = {q_head.p3, q_head.p2};
            c_in = {1'b0, q_head.p1[6:0]};
         end
         EV_FONT_HEADER: begin
            a_in = {8'd0, q_head.p0};
            b_in = {8'd0, q_head.p1};
            c_in = {1'b0, q_head.p2[6:0]};
            d_in = {1'b0, q_head.p3[6:0]};
         end
         EV_RULED_RANGE: begin
            a_in = {q_head.p1, q_head.p0};
            b_in = {q_head.p3, q_head.p2};
         end
         EV_RULED_PATTERN: begin
            a_in = {8'd0, q_head.p0};
            b_in = {8'd0, q_head.p1};
         end
         default: a_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ev_ff   <= q_head.ev;
         a_ff    <= a_in;
         b_ff    <= b_in;
         c_ff    <= c_in;
         d_ff    <= d_in;
         last_ff <= q_head.last;
      end
   end

   assign rsp.valid        = valid_ff;
   assign rsp.event_res    = ev_ff;
   assign rsp.arg_a        = a_ff;
   assign rsp.arg_b        = b_ff;
   assign rsp.arg_c        = c_ff;
   assign rsp.arg_d        = d_ff;
   assign rsp.payload_last = last_ff;

endmodule

FILE: rtl/core/thermal_printer_command_parser.sv
// ----------------------------------------------------------------------------
// Thermal printer command parser
// Decodes an ESC/POS style printer byte stream into command event beats.
// ----------------------------------------------------------------------------
// One byte beat is taken per cycle while the queue has room and no header
// count is in progress, and yields zero or one event beat. The byte that
// completes a bitmap or font definition header holds the input: the payload
// count goes through a two-step registered multiply before the next byte can
// be parsed. Classified commands wait in a four-entry queue in front of the
// event formatter, so the input keeps flowing while a result beat is stalled
// until that queue fills. Event beats pass the queue and the output register.
module thermal_printer_command_parser import tpcp_pkg::*; #(
   parameter int MAX_BITMAP_LINES = MAX_BITMAP_LINES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   tpcp_req_if.sink    req,
   tpcp_rsp_if.source  rsp
);

   logic    q_full;
   logic    q_push;
   rec_type q_push_rec;
   logic    q_pop;
   logic    q_valid;
   rec_type q_head;

   tpcp_front #(
      .MAX_BITMAP_LINES (MAX_BITMAP_LINES)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .q_full   (q_full),
      .push     (q_push),
      .push_rec (q_push_rec)
   );

   tpcp_queue #(
      .DEPTH (QUEUE_DEPTH_DEF)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_rec  (q_push_rec),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_valid),
      .head      (q_head)
   );

   tpcp_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_head  (q_head),
      .pop     (q_pop),
      .rsp     (rsp)
   );

endmodule

FILE: test/tb_thermal_printer_command_parser.sv
// ----------------------------------------------------------------------------
// Thermal printer command parser testbench
// Feeds directed and random printer byte streams through the parser, predicts
// each decoded event beat and compares the event beats field by field.
// ----------------------------------------------------------------------------
module tb_thermal_printer_command_parser;
   import tpcp_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int MAX_LINES = 1023;
   localparam int DRAIN_CYCLES = 20;
   localparam int MAX_RAND_PAYLOAD = 64;

   // One decoded event beat.
   typedef struct packed {
      logic [4:0]  ev;
      logic [15:0] a;
      logic [15:0] b;
      logic [7:0]  c;
      logic [7:0]  d;
      logic        last;
   } event_beat;

   // Byte stream decoder that mirrors the parser and holds pending events.
   class event_scoreboard;
      mode_type    mode;
      bit          locked;
      logic [7:0]  cmd;
      int unsigned remaining;
      logic [7:0]  prm [4];
      int unsigned prm_count;
      bit          kanji;
      logic [7:0]  kanji_lead;
      event_beat   pending [$];
      int          errors;

      function void clear();
         mode = MODE_TEXT;
         locked = 0;
         cmd = 0;
         remaining = 0;
         prm_count = 0;
         kanji = 0;
         kanji_lead = 0;
         errors = 0;
         pending.delete();
         for (int i = 0; i < 4; i++) begin
            prm[i] = 0;
         end
      endfunction

      function void push(ev_type ev, int unsigned a, int unsigned b = 0,
                         int unsigned c = 0, int unsigned d = 0, bit last = 0);
         event_beat e;
         e.ev = ev;
         e.a = a[15:0];
         e.b = b[15:0];
         e.c = c[7:0];
         e.d = d[7:0];
         e.last = last;
         pending.insert(pending.size(), e);
      endfunction

      function void end_command();
         remaining = 0;
         prm_count = 0;
         if (!(locked && mode == MODE_DC3)) begin
            mode = MODE_TEXT;
         end
      endfunction

      function void wait_params(int unsigned n);
         remaining = n;
         prm_count = 0;
      endfunction

      // Runs a command once all its parameter bytes are in.
      function void run_command();
         int unsigned h, cnt, lo, hi;
         int          span, fcnt;
         lo = prm[0] + prm[1] * 256;
         hi = prm[2] + prm[3] * 256;
         case (mode)
            MODE_ESC: begin
               case (cmd)
                  C_THREE, C_UA: push(EV_LINE_SPACE, prm[0]);
                  C_UI:    push(EV_REVERSE, prm[0] & 1);
                  C_UJ:    push(EV_FEED_FWD, prm[0]);
                  C_LJ:    push(EV_FEED_REV, prm[0]);
                  B_SPC:   push(EV_CHAR_SPACE, prm[0] & 8'h7F);
                  C_UW:    push(EV_DBL_WIDTH, prm[0] & 1);
                  C_LW:    push(EV_DBL_HEIGHT, prm[0] & 1);
                  C_MINUS: push(EV_UNDERLINE, prm[0] & 7);
                  C_EQUAL: push(EV_BMP_MSB, prm[0] & 1);
                  C_HASH:  push(EV_XOR_MODE, prm[0] & 1);
                  default: ;
               endcase
            end
            MODE_DC2: begin
               case (cmd)
                  C_UF: push(EV_FONT_SEL, prm[0] & 1);
                  C_UO: push(EV_CUSTOM_EN, prm[0] & 1);
                  C_LP: if (prm[0] != 0) push(EV_PEN_ADV, 1);
                  C_US: push(EV_BMP_PRINT, prm[0], prm[1] * 8);
                  C_UU: push(EV_BMP_DELETE, prm[0]);
                  C_UT: begin
                     h = hi;
                     if (h > MAX_LINES) h = MAX_LINES;
                     cnt = (prm[1] & 8'h7F) * h;
                     remaining = cnt > COUNT_MAX ? COUNT_MAX : cnt;
                     push(EV_BMP_HEADER, prm[0], h, prm[1] & 8'h7F);
                  end
                  C_UP: begin
                     span = int'(prm[1]) - int'(prm[0]) + 1;
                     fcnt = (((prm[2] & 8'h7F) + 7) / 8) * (prm[3] & 8'h7F) * span;
                     if (fcnt <= 0) remaining = 0;
                     else remaining = fcnt > COUNT_MAX ? COUNT_MAX : fcnt;
                     push(EV_FONT_HEADER, prm[0], prm[1], prm[2] & 8'h7F,
                          prm[3] & 8'h7F);
                  end
                  default: ;
               endcase
            end
            MODE_DC3: begin
               case (cmd)
                  C_UD: push(EV_RULED_RANGE, lo, lo);
                  C_UF: push(EV_RULED_PATTERN, prm[0], prm[1]);
                  C_UL: push(EV_RULED_RANGE, lo, hi);
                  default: ;
               endcase
            end
            default: ;
         endcase
      endfunction

      // Notes one accepted byte and predicts its event, if any.
      function void note_byte(logic [7:0] c);
         if (remaining > 0) begin
            if (prm_count >= 4) begin
               remaining--;
               push(cmd == C_UT ? EV_BMP_DATA : EV_FONT_DATA, c, 0, 0, 0,
                    remaining == 0);
               if (remaining == 0) end_command();
               return;
            end
            prm[prm_count[1:0]] = c;
            prm_count++;
            remaining--;
            if (remaining > 0) return;
            run_command();
            if (remaining == 0) end_command();
            return;
         end
         case (mode)
            MODE_ESC: begin
               cmd = c;
               case (c)
                  C_THREE, C_UA, C_UJ, C_LJ, B_SPC, C_UI, C_UW, C_LW, C_EQUAL,
                  C_HASH, C_MINUS: wait_params(1);
                  C_LI: begin mode = MODE_TEXT; push(EV_CUT, 0); end
                  C_UK: begin kanji = 1; mode = MODE_TEXT; end
                  C_UH: begin kanji = 0; mode = MODE_TEXT; end
                  C_TWO: begin mode = MODE_TEXT; push(EV_LINE_SPACE, 16); end
                  default: mode = MODE_TEXT;
               endcase
            end
            MODE_DC2: begin
               cmd = c;
               case (c)
                  C_UD, C_UF, C_UG, C_UU, C_LP, C_TILDE, C_UO: wait_params(1);
                  C_US: wait_params(2);
                  C_LM: wait_params(3);
                  C_UT, C_UP: wait_params(4);
                  default: mode = MODE_TEXT;
               endcase
            end
            MODE_DC3: begin
               cmd = c;
               case (c)
                  C_LPAR: locked = 1;
                  C_RPAR: begin locked = 0; mode = MODE_TEXT; end
                  C_UD, C_UF: wait_params(2);
                  C_UL: wait_params(4);
                  default: begin
                     if (c == C_PLUS) push(EV_RULED_MODE, 1);
                     else if (c == C_MINUS) push(EV_RULED_MODE, 0);
                     else if (c == C_UC) push(EV_RULED_CLEAR, 0);
                     else if (c == C_UP) push(EV_RULED_PRINT, 0);
                     if (!locked) mode = MODE_TEXT;
                  end
               endcase
            end
            default: begin
               case (c)
                  B_ESC: mode = MODE_ESC;
                  B_DC2: mode = MODE_DC2;
                  B_DC3: mode = MODE_DC3;
                  B_CR, B_LF: push(EV_LINE_END, 0);
                  B_CAN, B_NUL: ;
                  default: begin
                     if (!kanji) push(EV_CHAR, c);
                     else if (kanji_lead == 0) begin
                        if (c <= B_SPC) push(EV_CHAR, c);
                        else kanji_lead = c;
                     end else begin
                        push(EV_WIDE, {kanji_lead, c});
                        kanji_lead = 0;
                     end
                  end
               endcase
            end
         endcase
      endfunction

      // Compares one event beat with the oldest prediction.
      function void check_event(event_beat got);
         event_beat want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected event beat, expected none, actual %h",
                     $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.ev !== want.ev || got.a !== want.a || got.b !== want.b ||
             got.c !== want.c || got.d !== want.d || got.last !== want.last) begin
            $display("%0t: event mismatch, expected ev=%0d a=%h b=%h c=%h d=%h last=%b",
                     $time, want.ev, want.a, want.b, want.c, want.d, want.last);
            $display("%0t:                  actual ev=%0d a=%h b=%h c=%h d=%h last=%b",
                     $time, got.ev, got.a, got.b, got.c, got.d, got.last);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   send_idle_pct;
   int   recv_idle_pct;
   int   quiet_cycles;
   event_scoreboard board;

   tpcp_req_if req ();
   tpcp_rsp_if rsp ();

   thermal_printer_command_parser DUT (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // Sends one byte beat after an optional random gap; valid stays high after
   // the beat so that back to back beats need no second assignment.
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 0;
         @(posedge clock);
      end
      req.valid <= 1;
      req.byte_in <= b;
      do @(posedge clock); while (!req.ready);
      board.note_byte(b);
   endtask

   task automatic send_bytes(input logic [7:0] bs []);
      foreach (bs[i]) send_byte(bs[i]);
   endtask

   // Holds the stream until every predicted event has come out.
   task automatic drain();
      req.valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Random well formed commands with random content, and some noise.
   task automatic random_command();
      logic [7:0] esc1 [] = '{C_THREE, C_UA, C_UJ, C_LJ, B_SPC, C_UI, C_UW, C_LW,
                              C_EQUAL, C_HASH, C_MINUS};
      logic [7:0] esc0 [] = '{C_LI, C_UK, C_UH, C_TWO, C_UF, 8'h45};
      logic [7:0] dc2 [] = '{C_UD, C_UF, C_UG, C_UU, C_LP, C_TILDE, C_UO, C_US,
                             C_LM, C_UT, C_UP, 8'h52};
      logic [7:0] dc3 [] = '{C_LPAR, C_RPAR, C_UD, C_UF, C_UL, C_PLUS, C_MINUS,
                             C_UC, C_UP, C_UA};
      logic [7:0] c;
      int         kind;
      kind = $urandom_range(9);
      case (kind)
         0, 1: send_byte(8'($urandom));
         2: send_byte($urandom_range(1) ? B_CR : B_LF);
         3: begin
            send_byte(B_ESC);
            if ($urandom_range(1)) begin
               send_byte(esc1[$urandom_range(esc1.size() - 1)]);
               send_byte(8'($urandom));
            end else begin
               send_byte(esc0[$urandom_range(esc0.size() - 1)]);
            end
         end
         4, 5: begin
            send_byte(B_DC2);
            c = dc2[$urandom_range(dc2.size() - 1)];
            send_byte(c);
            if (c == C_UT) begin
               send_bytes('{8'($urandom), 8'($urandom_range(5)),
                            8'($urandom_range(4)), 8'h00});
            end else if (c == C_UP) begin
               c = 8'($urandom);
               send_bytes('{c, 8'(c + 8'($urandom_range(1))),
                            8'($urandom_range(16)), 8'($urandom_range(3))});
            end else begin
               repeat ($urandom_range(3)) send_byte(8'($urandom));
            end
            // Payload bytes, if the header asked for any; a long payload that
            // random noise opened is left to the following commands.
            for (int k = 0; k < MAX_RAND_PAYLOAD && board.remaining > 0 &&
                 board.prm_count >= 4; k++) begin
               send_byte(8'($urandom));
            end
         end
         6, 7: begin
            if (board.mode != MODE_DC3) send_byte(B_DC3);
            c = dc3[$urandom_range(dc3.size() - 1)];
            send_byte(c);
            repeat (board.remaining < 4 ? board.remaining : 4)
               send_byte(8'($urandom));
         end
         default: begin
            send_bytes('{B_ESC, $urandom_range(1) ? C_UK : C_UH});
            repeat ($urandom_range(4)) send_byte(8'($urandom));
         end
      endcase
   endtask

   // Result side: random stalls and the check of every event beat.
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            board.check_event({rsp.event_res, rsp.arg_a, rsp.arg_b, rsp.arg_c,
                               rsp.arg_d, rsp.payload_last});
         end
         rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog on cycles without any beat.
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      board = new();
      board.clear();
      reset = 1;
      req.valid = 0;
      req.byte_in = 0;
      rsp.ready = 0;
      send_idle_pct = 15;
      recv_idle_pct = 85;
      quiet_cycles = 0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part: text, controls, kanji, each command family.
      send_bytes('{8'h41, 8'hFF, B_NUL, B_CAN, B_CR, B_LF});
      send_bytes('{B_ESC, C_UK, 8'h20, 8'h81, B_CR, 8'hFF, B_ESC, C_UH});
      send_bytes('{B_ESC, C_LI, B_ESC, C_TWO, B_ESC, B_SPC, 8'hFF});
      send_bytes('{B_DC2, C_UT, 8'h07, 8'h81, 8'h02, 8'h00, 8'hAA, 8'h55});
      // Clamped line count with a zero width: the header ends the command.
      send_bytes('{B_DC2, C_UT, 8'h01, 8'h80, 8'hFF, 8'hFF});
      drain();
      send_idle_pct = 0;
      while (board.remaining > 0) send_byte(8'($urandom));
      send_bytes('{B_DC2, C_UP, 8'h50, 8'h40, 8'h18, 8'h02});
      send_bytes('{B_DC2, C_UP, 8'h00, 8'h00, 8'h09, 8'h01, 8'h12, 8'h34});
      send_bytes('{B_DC2, C_LP, 8'h00, B_DC2, C_LP, 8'h01, B_DC2, 8'h99});
      send_bytes('{B_DC3, C_LPAR, C_UL, 8'h01, 8'h02, 8'h03, 8'h04, C_PLUS,
                   8'hEE, C_RPAR});
      drain();

      // Random part in three idling phases.
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = ph == 0 ? 15 : (ph == 1 ? 85 : 0);
         recv_idle_pct = ph == 0 ? 85 : (ph == 1 ? 15 : 0);
         repeat (40) random_command();
      end
      drain();

      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
